FILE: hdl/murmur3_x64_128_hash_top_assert.svh
// assertion macros for the hash block
`ifndef MURMUR3_X64_128_HASH_TOP_ASSERT_SVH
`define MURMUR3_X64_128_HASH_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define M3H_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define M3H_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define M3H_ASSERT(label, prop, msg)
`define M3H_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: hdl/m3h_pkg.sv
package m3h_pkg;

  localparam logic [63:0] MIX_C1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] LANE_C1 = 64'h0000000052dce729;
  localparam logic [63:0] LANE_C2 = 64'h0000000038495ab5;
  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;

  localparam int CFG_IDX_W = 1;
  localparam int DATA_IN_W = 136;
  localparam int DATA_OUT_W = 128;
  localparam logic [1:0] PHASE_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_UPPER,
    CFG_SEED_LOWER
  } cfg_idx_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL,
    DP_MIX1A,
    DP_MIX1B,
    DP_MIX2A,
    DP_MIX2B,
    DP_TAIL,
    DP_FXOR,
    DP_FADD1,
    DP_FADD2,
    DP_FMLOAD,
    DP_FMSHIFT,
    DP_FSUM1,
    DP_FSUM2,
    DP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    MS_SCR1,
    MS_SCR2,
    MS_FMIX1,
    MS_FMIX2
  } mul_sel_t;

  typedef struct packed {
    dp_op_t     op;
    mul_sel_t   msel;
    logic [1:0] phase;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic full;
  } dp_stat_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  // keep the low n bytes, n in 0..8
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (n > 4'(i)) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: hdl/m3h_ctrl.sv
module m3h_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  m3h_pkg::dp_stat_t stat,
  output m3h_pkg::dp_cmd_t  cmd
);
  import m3h_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCR1,
    ST_SCR2,
    ST_MIX1A,
    ST_MIX1B,
    ST_MIX2A,
    ST_MIX2B,
    ST_TAIL,
    ST_FXOR,
    ST_FADD1,
    ST_FADD2,
    ST_FMLOAD,
    ST_FM1,
    ST_FMS1,
    ST_FM2,
    ST_FMS2,
    ST_FSUM1,
    ST_FSUM2,
    ST_OUT
  } state_t;

  state_t     state;
  logic [1:0] phase;
  logic       out_valid;
  logic       out_go;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_go   = (state == ST_OUT) && (!out_valid || m_tready);

  always_comb begin
    cmd.op    = DP_NOP;
    cmd.msel  = MS_SCR1;
    cmd.phase = phase;
    unique case (state)
      ST_IDLE:   cmd.op = s_tvalid ? DP_LOAD : DP_NOP;
      ST_SCR1:   cmd.op = DP_MUL;
      ST_SCR2: begin
        cmd.op   = DP_MUL;
        cmd.msel = MS_SCR2;
      end
      ST_MIX1A:  cmd.op = DP_MIX1A;
      ST_MIX1B:  cmd.op = DP_MIX1B;
      ST_MIX2A:  cmd.op = DP_MIX2A;
      ST_MIX2B:  cmd.op = DP_MIX2B;
      ST_TAIL:   cmd.op = DP_TAIL;
      ST_FXOR:   cmd.op = DP_FXOR;
      ST_FADD1:  cmd.op = DP_FADD1;
      ST_FADD2:  cmd.op = DP_FADD2;
      ST_FMLOAD: cmd.op = DP_FMLOAD;
      ST_FM1: begin
        cmd.op   = DP_MUL;
        cmd.msel = MS_FMIX1;
      end
      ST_FMS1:   cmd.op = DP_FMSHIFT;
      ST_FM2: begin
        cmd.op   = DP_MUL;
        cmd.msel = MS_FMIX2;
      end
      ST_FMS2:   cmd.op = DP_FMSHIFT;
      ST_FSUM1:  cmd.op = DP_FSUM1;
      ST_FSUM2:  cmd.op = DP_FSUM2;
      ST_OUT:    cmd.op = out_go ? DP_OUT : DP_NOP;
      default:   cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          phase <= '0;
          if (s_tvalid) begin
            state <= ST_SCR1;
          end
        end
        ST_SCR1, ST_SCR2, ST_FM1, ST_FM2: begin
          if (phase == PHASE_LAST) begin
            phase <= '0;
            unique case (state)
              ST_SCR1: state <= ST_SCR2;
              ST_SCR2: state <= stat.full ? ST_MIX1A : ST_TAIL;
              ST_FM1:  state <= ST_FMS1;
              default: state <= ST_FMS2;
            endcase
          end else begin
            phase <= phase + 2'd1;
          end
        end
        ST_MIX1A:  state <= ST_MIX1B;
        ST_MIX1B:  state <= ST_MIX2A;
        ST_MIX2A:  state <= ST_MIX2B;
        ST_MIX2B:  state <= stat.last ? ST_FXOR : ST_IDLE;
        ST_TAIL:   state <= ST_FXOR;
        ST_FXOR:   state <= ST_FADD1;
        ST_FADD1:  state <= ST_FADD2;
        ST_FADD2:  state <= ST_FMLOAD;
        ST_FMLOAD: state <= ST_FM1;
        ST_FMS1:   state <= ST_FM2;
        ST_FMS2:   state <= ST_FSUM1;
        ST_FSUM1:  state <= ST_FSUM2;
        ST_FSUM2:  state <= ST_OUT;
        ST_OUT: begin
          if (out_go) begin
            state <= ST_IDLE;
          end
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/m3h_datapath.sv
module m3h_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  m3h_pkg::dp_cmd_t                 cmd,
  output m3h_pkg::dp_stat_t                stat,
  input  logic [m3h_pkg::DATA_IN_W-1:0]    s_tdata,
  input  logic                             s_tlast,
  output logic [m3h_pkg::DATA_OUT_W-1:0]   m_tdata,
  input  logic                             cfg_wr,
  input  logic [m3h_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_data
);
  import m3h_pkg::*;

  logic [63:0] seed_upper;
  logic [63:0] seed_lower;
  logic [63:0] h1;
  logic [63:0] h2;
  logic [63:0] k1;
  logic [63:0] k2;
  logic [63:0] acc1;
  logic [63:0] acc2;
  logic [63:0] msg_len;
  logic        in_message;
  logic        is_last;
  logic        is_full;
  logic [63:0] hash_upper;
  logic [63:0] hash_lower;

  logic [63:0] word_low;
  logic [63:0] word_high;
  logic [4:0]  byte_count;
  logic [4:0]  cnt_sat;
  logic [4:0]  eff_cnt;
  logic [3:0]  lo_n;
  logic [3:0]  hi_n;

  logic [63:0] src1;
  logic [63:0] src2;
  logic [63:0] mc1;
  logic [63:0] mc2;
  logic [31:0] ma1;
  logic [31:0] mb1;
  logic [31:0] ma2;
  logic [31:0] mb2;
  logic [63:0] prod1;
  logic [63:0] prod2;
  logic [63:0] mix1;
  logic [63:0] mix2;

  assign word_low   = s_tdata[63:0];
  assign word_high  = s_tdata[127:64];
  assign byte_count = s_tdata[132:128];
  assign cnt_sat    = (byte_count > 5'd16) ? 5'd16 : byte_count;
  assign eff_cnt    = s_tlast ? cnt_sat : 5'd16;
  assign lo_n       = (eff_cnt >= 5'd8) ? 4'd8 : eff_cnt[3:0];
  assign hi_n       = (eff_cnt > 5'd8) ? 4'(eff_cnt - 5'd8) : 4'd0;

  assign stat.last = is_last;
  assign stat.full = is_full;
  assign m_tdata   = {hash_lower, hash_upper};

  always_comb begin
    src1 = k1;
    src2 = k2;
    mc1  = MIX_C1;
    mc2  = MIX_C2;
    unique case (cmd.msel)
      MS_SCR1: begin
        mc1 = MIX_C1;
        mc2 = MIX_C2;
      end
      MS_SCR2: begin
        src1 = rotl64(k1, 31);
        src2 = rotl64(k2, 33);
        mc1  = MIX_C2;
        mc2  = MIX_C1;
      end
      MS_FMIX1: begin
        mc1 = FMIX_C1;
        mc2 = FMIX_C1;
      end
      MS_FMIX2: begin
        mc1 = FMIX_C2;
        mc2 = FMIX_C2;
      end
      default: begin
        mc1 = MIX_C1;
        mc2 = MIX_C2;
      end
    endcase
  end

  // one 32x32 partial product per lane per cycle
  always_comb begin
    ma1 = src1[31:0];
    mb1 = mc1[31:0];
    ma2 = src2[31:0];
    mb2 = mc2[31:0];
    if (cmd.phase == 2'd1) begin
      mb1 = mc1[63:32];
      mb2 = mc2[63:32];
    end else if (cmd.phase == PHASE_LAST) begin
      ma1 = src1[63:32];
      ma2 = src2[63:32];
    end
  end

  assign prod1 = {32'd0, ma1} * {32'd0, mb1};
  assign prod2 = {32'd0, ma2} * {32'd0, mb2};
  assign mix1  = rotl64(h1 ^ k1, 27) + h2;
  assign mix2  = rotl64(h2 ^ k2, 31) + h1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_upper <= '0;
      seed_lower <= '0;
      h1         <= '0;
      h2         <= '0;
      msg_len    <= '0;
      in_message <= 1'b0;
      is_last    <= 1'b0;
      is_full    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SEED_UPPER: begin
            seed_upper <= cfg_data;
            if (!in_message) begin
              h1 <= cfg_data;
            end
          end
          CFG_SEED_LOWER: begin
            seed_lower <= cfg_data;
            if (!in_message) begin
              h2 <= cfg_data;
            end
          end
          default: ;
        endcase
      end
      unique case (cmd.op)
        DP_LOAD: begin
          msg_len    <= msg_len + 64'(eff_cnt);
          in_message <= 1'b1;
          is_last    <= s_tlast;
          is_full    <= (eff_cnt == 5'd16);
        end
        DP_MIX1A: h1 <= mix1;
        DP_MIX1B: h1 <= h1 + (h1 << 2) + LANE_C1;
        DP_MIX2A: h2 <= mix2;
        DP_MIX2B: h2 <= h2 + (h2 << 2) + LANE_C2;
        DP_TAIL: begin
          h1 <= h1 ^ k1;
          h2 <= h2 ^ k2;
        end
        DP_FXOR: begin
          h1 <= h1 ^ msg_len;
          h2 <= h2 ^ msg_len;
        end
        DP_FADD1: h1 <= h1 + h2;
        DP_FADD2: h2 <= h2 + h1;
        DP_OUT: begin
          h1         <= seed_upper;
          h2         <= seed_lower;
          msg_len    <= '0;
          in_message <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        k1 <= word_low & byte_mask(lo_n);
        k2 <= word_high & byte_mask(hi_n);
      end
      DP_MUL: begin
        if (cmd.phase == 2'd0) begin
          acc1 <= prod1;
          acc2 <= prod2;
        end else if (cmd.phase == 2'd1) begin
          acc1[63:32] <= acc1[63:32] + prod1[31:0];
          acc2[63:32] <= acc2[63:32] + prod2[31:0];
        end else begin
          k1 <= {acc1[63:32] + prod1[31:0], acc1[31:0]};
          k2 <= {acc2[63:32] + prod2[31:0], acc2[31:0]};
        end
      end
      DP_FMLOAD: begin
        k1 <= h1 ^ (h1 >> 33);
        k2 <= h2 ^ (h2 >> 33);
      end
      DP_FMSHIFT: begin
        k1 <= k1 ^ (k1 >> 33);
        k2 <= k2 ^ (k2 >> 33);
      end
      DP_FSUM1: k1 <= k1 + k2;
      DP_FSUM2: k2 <= k2 + k1;
      DP_OUT: begin
        hash_upper <= k1;
        hash_lower <= k2;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/murmur3_x64_128_hash_top.sv
// 128-bit streaming hash, two 64-bit lanes with a split 128-bit seed.
// input: s_tvalid/s_tready/s_tdata/s_tlast, one 16-byte block per request;
//   tdata carries word_low, word_high and byte_count, tlast closes the message.
// output: m_tvalid/m_tready/m_tdata, one 128-bit hash per message.
// config: cfg_valid/cfg_ready/cfg_index/cfg_data, index 0 seed_upper,
//   index 1 seed_lower; cfg_ready is always high. between messages a seed
//   write also reloads its lane.
// a full block takes the request, runs the two scramble multiplies (each a
//   64-bit product built from three 32x32 partial products) and then the
//   lane mixing; the next block is taken only once the last one is mixed.
// a last block shorter than 16 bytes uses a tail step instead of the lane
//   mixing; a last block then goes through finalization, the fmix
//   multiplies on the same shared multiplier pair, before m_tvalid rises.
// reset clears seeds, lanes and length to zero and drops m_tvalid.
// the result sits in an output register; if the receiver stalls, the next
//   message is still taken and only stops at its own result until m_tready.
module murmur3_x64_128_hash_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // word_low [63:0], word_high [127:64], byte_count [132:128], zero fill
  input  logic [m3h_pkg::DATA_IN_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // hash_upper [63:0], hash_lower [127:64]
  output logic [m3h_pkg::DATA_OUT_W-1:0]    m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [m3h_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data
);
  import m3h_pkg::*;

  `include "murmur3_x64_128_hash_top_assert.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  m3h_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  m3h_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tdata   (m_tdata),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  `M3H_ASSERT(a_no_overwrite, (cmd.op == DP_OUT) |-> (!m_tvalid || m_tready), "result lost")
  `M3H_ASSERT(a_ready_idle, s_tready |-> (cmd.op == DP_LOAD || cmd.op == DP_NOP), "busy on accept")
  `M3H_ASSERT(a_load_on_accept, (cmd.op == DP_LOAD) |-> (s_tvalid && s_tready), "stray load")
  `M3H_ASSERT_RST(a_reset_clears_valid, rst |=> !m_tvalid, "m_tvalid high after reset")

endmodule

FILE: bench/murmur3_x64_128_hash_top_tb.sv
module murmur3_x64_128_hash_top_tb;
  import m3h_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASES = 6;

  typedef struct {
    logic [63:0] hash_upper;
    logic [63:0] hash_lower;
  } digest_t;

  class digest_scoreboard;
    logic [63:0] seed_up;
    logic [63:0] seed_dn;
    logic [63:0] lane_a;
    logic [63:0] lane_b;
    logic [63:0] byte_len;
    bit          open_msg;
    digest_t     pending_digests[$];
    int          mismatches;

    function new();
      seed_up = '0;
      seed_dn = '0;
      lane_a = '0;
      lane_b = '0;
      byte_len = '0;
      open_msg = 1'b0;
      mismatches = 0;
    endfunction

    function logic [63:0] spin(logic [63:0] x, int r);
      logic [127:0] d;
      d = {x, x} << r;
      return d[127:64];
    endfunction

    function logic [63:0] scr_a(logic [63:0] w);
      return spin(w * MIX_C1, 31) * MIX_C2;
    endfunction

    function logic [63:0] scr_b(logic [63:0] w);
      return spin(w * MIX_C2, 33) * MIX_C1;
    endfunction

    function logic [63:0] avalanche(logic [63:0] v);
      logic [63:0] t;
      t = v ^ (v >> 33);
      t = t * FMIX_C1;
      t = t ^ (t >> 33);
      t = t * FMIX_C2;
      return t ^ (t >> 33);
    endfunction

    function logic [63:0] low_bytes(logic [63:0] w, int n);
      if (n >= 8) return w;
      return w & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function void mix_block(logic [63:0] lo, logic [63:0] hi);
      lane_a = spin(lane_a ^ scr_a(lo), 27) + lane_b;
      lane_a = lane_a * 64'd5 + LANE_C1;
      lane_b = spin(lane_b ^ scr_b(hi), 31) + lane_a;
      lane_b = lane_b * 64'd5 + LANE_C2;
    endfunction

    function void set_seed(cfg_idx_t idx, logic [63:0] val);
      case (idx)
        CFG_SEED_UPPER: begin
          seed_up = val;
          if (!open_msg) lane_a = val;
        end
        CFG_SEED_LOWER: begin
          seed_dn = val;
          if (!open_msg) lane_b = val;
        end
        default: ;
      endcase
    endfunction

    function void absorb_request(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt,
                                 logic last);
      int      n;
      digest_t d;
      if (!last) begin
        mix_block(lo, hi);
        byte_len += 64'd16;
        open_msg = 1'b1;
        return;
      end
      n = (cnt > 5'd16) ? 16 : int'(cnt);
      if (n == 16) begin
        mix_block(lo, hi);
      end else begin
        if (n > 8) lane_b ^= scr_b(low_bytes(hi, n - 8));
        if (n > 0) lane_a ^= scr_a(low_bytes(lo, n));
      end
      byte_len += 64'(n);
      d.hash_upper = lane_a ^ byte_len;
      d.hash_lower = lane_b ^ byte_len;
      d.hash_upper += d.hash_lower;
      d.hash_lower += d.hash_upper;
      d.hash_upper = avalanche(d.hash_upper);
      d.hash_lower = avalanche(d.hash_lower);
      d.hash_upper += d.hash_lower;
      d.hash_lower += d.hash_upper;
      pending_digests.push_back(d);
      lane_a = seed_up;
      lane_b = seed_dn;
      byte_len = '0;
      open_msg = 1'b0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < 100) $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
    endtask

    task check_digest(logic [63:0] got_up, logic [63:0] got_lo);
      digest_t d;
      if (pending_digests.size() == 0) begin
        report("unexpected hash", got_up, '0);
        return;
      end
      d = pending_digests.pop_front();
      if (got_up !== d.hash_upper) report("hash_upper", got_up, d.hash_upper);
      if (got_lo !== d.hash_lower) report("hash_lower", got_lo, d.hash_lower);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_IN_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_OUT_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [63:0]           cfg_data = '0;

  digest_scoreboard sb = new();
  int  tx_idle_pct = 16;
  int  rx_idle_pct = 16;
  bit  stall_pending = 1'b0;
  int  quiet_cycles = 0;

  murmur3_x64_128_hash_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver with random stalls and one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_pending) begin
        stall_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_digest(m_tdata[63:0], m_tdata[127:64]);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_block(input logic [63:0] lo, hi, input logic [4:0] cnt,
                            input logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, cnt, hi, lo};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.absorb_request(lo, hi, cnt, last);
  endtask

  task automatic write_seed(input cfg_idx_t idx, input logic [63:0] val);
    s_tvalid <= 1'b0;
    while (sb.pending_digests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_seed(idx, val);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int rand_body_len();
    case ($urandom_range(9))
      0, 1, 2: return 0;
      8: return $urandom_range(5, 12);
      9: return $urandom_range(13, 24);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // one message with random content, returns the number of requests sent
  task automatic send_message(output int sent);
    int body;
    body = rand_body_len();
    for (int i = 0; i < body; i++)
      send_block(rand_word(), rand_word(), 5'($urandom_range(31)), 1'b0);
    send_block(rand_word(), rand_word(), 5'($urandom_range(16)), 1'b1);
    sent = body + 1;
  endtask

  initial begin
    int sent;
    int phase_count;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_block('0, '0, 5'd0, 1'b1);
    write_seed(CFG_SEED_UPPER, '1);
    write_seed(CFG_SEED_LOWER, '0);
    send_block('1, '1, 5'd16, 1'b1);
    send_block(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 5'd1, 1'b1);
    send_block(rand_word(), rand_word(), 5'd8, 1'b1);
    send_block(rand_word(), rand_word(), 5'd9, 1'b1);
    send_block('1, '1, 5'd15, 1'b1);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd0, 1'b0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd5, 1'b1);
    send_block(rand_word(), rand_word(), 5'd17, 1'b1);
    send_block(rand_word(), rand_word(), 5'd31, 1'b1);
    send_block('1, '0, 5'd31, 1'b0);
    send_block('0, '1, 5'd0, 1'b1);
    // seed writes inside a message only take effect from the next one
    send_block(rand_word(), rand_word(), 5'd16, 1'b0);
    write_seed(CFG_SEED_LOWER, 64'h0123456789abcdef);
    write_seed(CFG_SEED_UPPER, 64'hfedcba9876543210);
    send_block(rand_word(), rand_word(), 5'd12, 1'b1);
    send_block(rand_word(), rand_word(), 5'd3, 1'b1);
    send_block(rand_word(), rand_word(), 5'd16, 1'b0);
    send_block(rand_word(), rand_word(), 5'd16, 1'b0);
    send_block(rand_word(), rand_word(), 5'd16, 1'b1);

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_seed(CFG_SEED_UPPER, '0);
          write_seed(CFG_SEED_LOWER, '0);
        end
        1: begin
          write_seed(CFG_SEED_UPPER, '1);
          write_seed(CFG_SEED_LOWER, '1);
        end
        default: begin
          write_seed(CFG_SEED_UPPER, {$urandom, $urandom});
          write_seed(CFG_SEED_LOWER, {$urandom, $urandom});
        end
      endcase
      tx_idle_pct = (p == 2) ? 0 : 16;
      rx_idle_pct = (p == 2) ? 0 : 16;
      if (p == 3) stall_pending = 1'b1;
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        send_message(sent);
        phase_count += sent;
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending_digests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
